>>> rtl/nsc_pkg.sv
// Shared types, codes and helper functions of the NMEA sentence checksum checker.
// No dependencies; imported by nsc_core, nmea_sentence_checksum_checker and the testbench.
`default_nettype none

package nsc_pkg;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_BODY = 2'd1,
      PH_HEX  = 2'd2
   } phase_type;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BAD    = 2'd1;
   localparam logic [1:0] ST_SYNTAX = 2'd2;

   localparam logic [2:0] TYPE_RMC     = 3'd0;
   localparam logic [2:0] TYPE_GGA     = 3'd1;
   localparam logic [2:0] TYPE_VTG     = 3'd2;
   localparam logic [2:0] TYPE_GSA     = 3'd3;
   localparam logic [2:0] TYPE_GSV     = 3'd4;
   localparam logic [2:0] TYPE_GLL     = 3'd5;
   localparam logic [2:0] TYPE_UNKNOWN = 3'd6;

   localparam logic [7:0] CHR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHR_STAR    = 8'h2A;
   localparam logic [7:0] CHR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHR_COMMA   = 8'h2C;

   localparam logic [7:0] MAX_LENGTH_RESET = 8'd82;

   localparam logic [39:0] HDR_RMC = "GPRMC";
   localparam logic [39:0] HDR_GGA = "GPGGA";
   localparam logic [39:0] HDR_VTG = "GPVTG";
   localparam logic [39:0] HDR_GSA = "GPGSA";
   localparam logic [39:0] HDR_GSV = "GPGSV";
   localparam logic [39:0] HDR_GLL = "GPGLL";

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] sentence_type;
      logic [7:0] computed_checksum;
      logic [7:0] received_checksum;
   } result_type;

   function automatic logic [2:0] classify(input logic [39:0] hdr);
      logic [2:0] code;
      code = TYPE_UNKNOWN;
      if (hdr == HDR_RMC) code = TYPE_RMC;
      else if (hdr == HDR_GGA) code = TYPE_GGA;
      else if (hdr == HDR_VTG) code = TYPE_VTG;
      else if (hdr == HDR_GSA) code = TYPE_GSA;
      else if (hdr == HDR_GSV) code = TYPE_GSV;
      else if (hdr == HDR_GLL) code = TYPE_GLL;
      return code;
   endfunction

   // bit 4 set means not a hex digit
   function automatic logic [4:0] hex_of(input logic [7:0] b);
      logic [4:0] d;
      d = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) d = {1'b0, b[3:0]};
      else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
         d = {1'b0, b[3:0] + 4'd9};
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/nsc_core.sv
// Sentence parser: phase machine, running XOR, header capture and hex checksum read.
// Depends on nsc_pkg.
`default_nettype none

module nsc_core
   import nsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic [7:0] max_length,
   output logic            emit,
   output result_type      res
);

   phase_type  phase_ff, phase_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  count_ff, count_in;
   logic [39:0] hdr_ff, hdr_in;
   logic [2:0]  hpos_ff, hpos_in;
   logic [2:0]  type_ff, type_in;
   logic [7:0]  hex_ff, hex_in;
   logic        hcnt_ff, hcnt_in;

   logic [4:0] digit;
   logic [7:0] hex_next;
   logic       is_hex;
   logic       too_long;

   assign digit    = hex_of(data_byte);
   assign is_hex   = ~digit[4];
   assign hex_next = {hex_ff[3:0], digit[3:0]};
   assign too_long = count_ff >= max_length;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            PH_BODY: begin
               if (data_byte == CHR_STAR) phase_in = PH_HEX;
               else if (data_byte == CHR_NEWLINE || too_long) phase_in = PH_HUNT;
               else phase_in = PH_BODY;
            end
            PH_HEX: begin
               if (is_hex) phase_in = hcnt_ff ? PH_HUNT : PH_HEX;
               else if (data_byte == CHR_DOLLAR) phase_in = PH_BODY;
               else phase_in = PH_HUNT;
            end
            default: begin
               phase_in = (data_byte == CHR_DOLLAR) ? PH_BODY : PH_HUNT;
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      xor_in   = xor_ff;
      count_in = count_ff;
      hdr_in   = hdr_ff;
      hpos_in  = hpos_ff;
      type_in  = type_ff;
      hex_in   = hex_ff;
      hcnt_in  = hcnt_ff;
      emit     = 1'b0;
      res.status            = (hex_ff == xor_ff) ? ST_OK : ST_BAD;
      res.sentence_type     = type_ff;
      res.computed_checksum = xor_ff;
      res.received_checksum = hex_ff;
      if (step) begin
         unique case (phase_ff)
            PH_BODY: begin
               if (data_byte == CHR_STAR) begin
                  hex_in  = '0;
                  hcnt_in = 1'b0;
               end else if (data_byte == CHR_NEWLINE || too_long) begin
                  hex_in = '0;
                  emit   = 1'b1;
                  res.status            = ST_SYNTAX;
                  res.received_checksum = '0;
               end else begin
                  xor_in   = xor_ff ^ data_byte;
                  count_in = count_ff + 8'd1;
                  if (hpos_ff < 3'd5) begin
                     hdr_in  = {hdr_ff[31:0], data_byte};
                     hpos_in = hpos_ff + 3'd1;
                  end else if (hpos_ff == 3'd5) begin
                     type_in = (data_byte == CHR_COMMA) ? classify(hdr_ff) : TYPE_UNKNOWN;
                     hpos_in = 3'd6;
                  end
               end
            end
            PH_HEX: begin
               if (is_hex) begin
                  hex_in  = hex_next;
                  hcnt_in = 1'b1;
                  if (hcnt_ff) begin
                     emit = 1'b1;
                     res.status            = (hex_next == xor_ff) ? ST_OK : ST_BAD;
                     res.received_checksum = hex_next;
                  end
               end else begin
                  emit = 1'b1;
                  if (data_byte == CHR_DOLLAR) begin
                     xor_in   = '0;
                     count_in = '0;
                     hdr_in   = '0;
                     hpos_in  = '0;
                     type_in  = TYPE_UNKNOWN;
                     hex_in   = '0;
                     hcnt_in  = 1'b0;
                  end
               end
            end
            default: begin
               if (data_byte == CHR_DOLLAR) begin
                  xor_in   = '0;
                  count_in = '0;
                  hdr_in   = '0;
                  hpos_in  = '0;
                  type_in  = TYPE_UNKNOWN;
                  hex_in   = '0;
                  hcnt_in  = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         xor_ff   <= '0;
         count_ff <= '0;
         hdr_ff   <= '0;
         hpos_ff  <= '0;
         type_ff  <= TYPE_UNKNOWN;
         hex_ff   <= '0;
         hcnt_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         count_ff <= count_in;
         hdr_ff   <= hdr_in;
         hpos_ff  <= hpos_in;
         type_ff  <= type_in;
         hex_ff   <= hex_in;
         hcnt_ff  <= hcnt_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/nmea_sentence_checksum_checker.sv
// NMEA sentence checksum checker: input byte register, parser, result register.
// A result reaches the result register after the byte that ends it passes the input byte register.
// Throughput: one byte per cycle; stalls only
// when the result register is full and not taken.
// Reset (synchronous): phase to hunt, max_length to 82, both registers emptied.
// Depends on nsc_pkg and nsc_core.
`default_nettype none

module nmea_sentence_checksum_checker
   import nsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_max_length,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic [2:0]      rsp_sentence_type,
   output logic [7:0]      rsp_computed_checksum,
   output logic [7:0]      rsp_received_checksum
);

   logic [7:0] max_length_ff, max_length_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       advance;
   logic       emit;
   result_type res;

   // hold configuration transfers while a byte waits in the input register
   assign csr_ready = !in_valid_ff;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      max_length_in = (csr_valid && csr_ready) ? csr_max_length : max_length_ff;
      in_valid_in   = req_ready ? req_valid : in_valid_ff;
      in_byte_in    = (req_valid && req_ready) ? req_data_byte : in_byte_ff;
      if (advance) out_valid_in = emit;
      else out_valid_in = out_valid_ff && !rsp_ready;
      out_in = (advance && emit) ? res : out_ff;
   end

   nsc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .max_length (max_length_ff),
      .emit       (emit),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         max_length_ff <= max_length_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_ff.status;
   assign rsp_sentence_type     = out_ff.sentence_type;
   assign rsp_computed_checksum = out_ff.computed_checksum;
   assign rsp_received_checksum = out_ff.received_checksum;

`ifndef SYNTH
   a_syntax_no_rx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SYNTAX |-> rsp_received_checksum == 8'd0)
      else $error("syntax error result carries a received checksum");
   a_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_computed_checksum == rsp_received_checksum)
      else $error("ok status with differing checksums");
   a_bad_mismatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BAD |-> rsp_computed_checksum != rsp_received_checksum)
      else $error("mismatch status with equal checksums");
   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sentence_type != 3'd7 && rsp_status != 2'd3)
      else $error("result code out of range");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench of nmea_sentence_checksum_checker: a short stimulus table, then NMEA-like
// sentences and noise under several max_length settings, checked against a local parser.
// Depends on nsc_pkg and the RTL of the checker.
`timescale 1ns / 1ps

module tb;
   import nsc_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BYTES  = 170;

   typedef struct packed {
      logic [7:0] data;
      logic       set_len;
      logic [7:0] len;
      logic       typed;
      result_type want;
   } stim_row_type;

   // hunt extremes, early newline, empty body, dollar after star, two digits,
   // non-hex after star, bad checksum, overlength, dollar inside the body
   localparam stim_row_type DIRECTED [0:26] = '{
      '{8'h00,       1'b0, 8'd0, 1'b0, '0},
      '{8'hFF,       1'b0, 8'd0, 1'b0, '0},
      '{CHR_DOLLAR,  1'b0, 8'd0, 1'b0, '0},
      '{CHR_NEWLINE, 1'b0, 8'd0, 1'b1, '{ST_SYNTAX, TYPE_UNKNOWN, 8'h00, 8'h00}},
      '{CHR_DOLLAR,  1'b0, 8'd0, 1'b0, '0},
      '{CHR_STAR,    1'b0, 8'd0, 1'b0, '0},
      '{CHR_DOLLAR,  1'b0, 8'd0, 1'b1, '{ST_OK, TYPE_UNKNOWN, 8'h00, 8'h00}},
      '{"A",         1'b0, 8'd0, 1'b0, '0},
      '{CHR_STAR,    1'b0, 8'd0, 1'b0, '0},
      '{"4",         1'b0, 8'd0, 1'b0, '0},
      '{"1",         1'b0, 8'd0, 1'b1, '{ST_OK, TYPE_UNKNOWN, 8'h41, 8'h41}},
      '{CHR_DOLLAR,  1'b0, 8'd0, 1'b0, '0},
      '{CHR_STAR,    1'b0, 8'd0, 1'b0, '0},
      '{"g",         1'b0, 8'd0, 1'b1, '{ST_OK, TYPE_UNKNOWN, 8'h00, 8'h00}},
      '{CHR_DOLLAR,  1'b0, 8'd0, 1'b0, '0},
      '{"a",         1'b0, 8'd0, 1'b0, '0},
      '{CHR_STAR,    1'b0, 8'd0, 1'b0, '0},
      '{"f",         1'b0, 8'd0, 1'b0, '0},
      '{"Z",         1'b0, 8'd0, 1'b0, '0},
      '{CHR_DOLLAR,  1'b1, 8'd1, 1'b0, '0},
      '{"a",         1'b0, 8'd0, 1'b0, '0},
      '{"b",         1'b0, 8'd0, 1'b1, '{ST_SYNTAX, TYPE_UNKNOWN, 8'h61, 8'h00}},
      '{CHR_DOLLAR,  1'b0, 8'd0, 1'b0, '0},
      '{CHR_DOLLAR,  1'b0, 8'd0, 1'b0, '0},
      '{CHR_STAR,    1'b0, 8'd0, 1'b0, '0},
      '{"2",         1'b0, 8'd0, 1'b0, '0},
      '{"4",         1'b0, 8'd0, 1'b1, '{ST_OK, TYPE_UNKNOWN, 8'h24, 8'h24}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_max_length = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [2:0] rsp_sentence_type;
   logic [7:0] rsp_computed_checksum;
   logic [7:0] rsp_received_checksum;

   // parser state
   phase_type   scan_phase = PH_HUNT;
   logic [7:0]  run_xor = 8'd0;
   logic [7:0]  body_len = 8'd0;
   logic [39:0] hdr_shift = 40'd0;
   logic [2:0]  hdr_len = 3'd0;
   logic [2:0]  kind = TYPE_UNKNOWN;
   logic [7:0]  hex_acc = 8'd0;
   logic [1:0]  hex_digits = 2'd0;
   logic [7:0]  len_limit = MAX_LENGTH_RESET;

   result_type expected_results [$];
   int  fail_count = 0;
   int  results_seen = 0;
   int  bad_seen = 0;
   int  syntax_seen = 0;
   int  sent_bytes = 0;
   int  settings = 0;
   int  cycles = 0;
   bit  calm = 1'b0;
   bit  hold_off = 1'b0;
   bit  pressure_req = 1'b0;

   nmea_sentence_checksum_checker i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_max_length        (csr_max_length),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_sentence_type     (rsp_sentence_type),
      .rsp_computed_checksum (rsp_computed_checksum),
      .rsp_received_checksum (rsp_received_checksum)
   );

   always #5 clock = ~clock;

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= 20) $display("mismatch: %0s (result %0d)", msg, results_seen);
   endtask

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      int v;
      v = $urandom_range(hi, lo);
      return v[7:0];
   endfunction

   function automatic logic [4:0] nibble_of(input logic [7:0] b);
      logic [7:0] v;
      v = 8'hFF;
      if (b >= "0" && b <= "9") v = b - "0";
      else if (b >= "A" && b <= "F") v = b - "A" + 8'd10;
      else if (b >= "a" && b <= "f") v = b - "a" + 8'd10;
      return (v < 8'd16) ? {1'b0, v[3:0]} : 5'h10;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 4'd10) return "0" + {4'd0, v};
      return (lower ? "a" : "A") + {4'd0, v} - 8'd10;
   endfunction

   function automatic logic [2:0] header_kind(input logic [39:0] h);
      case (h)
         "GPRMC": return TYPE_RMC;
         "GPGGA": return TYPE_GGA;
         "GPVTG": return TYPE_VTG;
         "GPGSA": return TYPE_GSA;
         "GPGSV": return TYPE_GSV;
         "GPGLL": return TYPE_GLL;
         default: return TYPE_UNKNOWN;
      endcase
   endfunction

   // advance the parser by one transferred byte and queue any result it ends
   task automatic track_byte(input logic [7:0] b, input bit typed, input result_type row_want);
      result_type r;
      logic [4:0] nib;
      bit fire;
      bit restart;
      fire = 1'b0;
      restart = 1'b0;
      r = '0;
      sent_bytes++;
      case (scan_phase)
         PH_BODY: begin
            if (b == CHR_STAR) begin
               scan_phase = PH_HEX;
               hex_acc = 8'd0;
               hex_digits = 2'd0;
            end else if (b == CHR_NEWLINE || body_len >= len_limit) begin
               hex_acc = 8'd0;
               scan_phase = PH_HUNT;
               fire = 1'b1;
               r.status = ST_SYNTAX;
            end else begin
               run_xor ^= b;
               body_len++;
               if (hdr_len < 3'd5) begin
                  hdr_shift = {hdr_shift[31:0], b};
                  hdr_len++;
               end else if (hdr_len == 3'd5) begin
                  kind = (b == CHR_COMMA) ? header_kind(hdr_shift) : TYPE_UNKNOWN;
                  hdr_len = 3'd6;
               end
            end
         end
         PH_HEX: begin
            nib = nibble_of(b);
            if (!nib[4]) begin
               hex_acc = {hex_acc[3:0], nib[3:0]};
               hex_digits++;
               fire = (hex_digits == 2'd2);
               if (fire) scan_phase = PH_HUNT;
            end else begin
               fire = 1'b1;
               restart = (b == CHR_DOLLAR);
               scan_phase = PH_HUNT;
            end
            r.status = (hex_acc == run_xor) ? ST_OK : ST_BAD;
         end
         default: restart = (b == CHR_DOLLAR);
      endcase
      if (fire) begin
         r.sentence_type = kind;
         r.computed_checksum = run_xor;
         r.received_checksum = hex_acc;
         expected_results.push_back(typed ? row_want : r);
      end else if (typed) begin
         report($sformatf("table row %0h should end a sentence", b));
      end
      if (restart) begin
         scan_phase = PH_BODY;
         run_xor = 8'd0;
         body_len = 8'd0;
         hdr_shift = 40'd0;
         hdr_len = 3'd0;
         kind = TYPE_UNKNOWN;
         hex_acc = 8'd0;
         hex_digits = 2'd0;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed, input result_type want);
      while (!calm && $urandom_range(99, 0) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_byte(b, typed, want);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_len(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_max_length <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      len_limit = v;
      settings++;
   endtask

   task automatic send_sentence();
      logic [7:0]  body [$];
      logic [7:0]  sum;
      logic [7:0]  c;
      logic [39:0] hdr;
      int shape, pick, n, i;
      bit lower;
      shape = $urandom_range(99, 0);
      pick = $urandom_range(7, 0);
      lower = 1'($urandom_range(1, 0));
      hdr = 40'd0;
      case (pick)
         0: hdr = "GPRMC";
         1: hdr = "GPGGA";
         2: hdr = "GPVTG";
         3: hdr = "GPGSA";
         4: hdr = "GPGSV";
         5: hdr = "GPGLL";
         default: for (i = 0; i < 5; i++) hdr = {hdr[31:0], rand_byte(65, 90)};
      endcase
      n = (pick == 7) ? $urandom_range(4, 0) : 5;
      for (i = 0; i < n; i++) body.push_back(hdr[39 - 8*i -: 8]);
      if (pick != 7) begin
         c = CHR_COMMA;
         if ($urandom_range(9, 0) == 0) c = rand_byte(33, 126);
         if (c == CHR_STAR) c = "X";
         body.push_back(c);
      end
      n = $urandom_range(20, 0);
      if (shape >= 90 && shape < 95) n = len_limit + 1 + $urandom_range(2, 0) - body.size();
      for (i = 0; i < n; i++) begin
         if ($urandom_range(19, 0) == 0) c = rand_byte(0, 255);
         else c = rand_byte(32, 126);
         if (c == CHR_STAR || c == CHR_NEWLINE) c = CHR_COMMA;
         body.push_back(c);
      end
      if (shape >= 95) begin
         if (body.size() == 0) body.push_back(CHR_NEWLINE);
         else body[$urandom_range(body.size() - 1, 0)] = CHR_NEWLINE;
      end
      sum = 8'd0;
      foreach (body[i]) sum ^= body[i];
      send_byte(CHR_DOLLAR, 1'b0, '0);
      foreach (body[i]) send_byte(body[i], 1'b0, '0);
      if (shape < 90) begin
         send_byte(CHR_STAR, 1'b0, '0);
         if (shape < 70) begin
            if ($urandom_range(5, 0) == 0) sum ^= rand_byte(1, 255);
            send_byte(hex_char(sum[7:4], lower), 1'b0, '0);
            send_byte(hex_char(sum[3:0], lower), 1'b0, '0);
         end else begin
            if (shape < 80) send_byte(hex_char(sum[7:4], lower), 1'b0, '0);
            pick = $urandom_range(2, 0);
            c = (pick == 0) ? "\r" : (pick == 1) ? CHR_COMMA : CHR_DOLLAR;
            send_byte(c, 1'b0, '0);
         end
      end
      send_byte("\r", 1'b0, '0);
      send_byte(CHR_NEWLINE, 1'b0, '0);
   endtask

   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         report($sformatf("result with nothing expected, status %0d checksum %0h",
                          rsp_status, rsp_computed_checksum));
         return;
      end
      want = expected_results.pop_front();
      results_seen++;
      if (want.status == ST_BAD) bad_seen++;
      if (want.status == ST_SYNTAX) syntax_seen++;
      if (rsp_status != want.status)
         report($sformatf("status %0d, want %0d", rsp_status, want.status));
      if (rsp_sentence_type != want.sentence_type)
         report($sformatf("sentence_type %0d, want %0d", rsp_sentence_type, want.sentence_type));
      if (rsp_computed_checksum != want.computed_checksum)
         report($sformatf("computed_checksum %0h, want %0h", rsp_computed_checksum,
                          want.computed_checksum));
      if (rsp_received_checksum != want.received_checksum)
         report($sformatf("received_checksum %0h, want %0h", rsp_received_checksum,
                          want.received_checksum));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result();
      if (hold_off) rsp_ready <= 1'b0;
      else if (calm) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99, 0) >= 33);
   end

   initial begin
      wait (pressure_req);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [7:0] lim;
      int ph, target, k, n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[k]) begin
         if (DIRECTED[k].set_len) begin
            wait_drained();
            write_len(DIRECTED[k].len);
         end
         send_byte(DIRECTED[k].data, DIRECTED[k].typed, DIRECTED[k].want);
      end
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: lim = 8'd255;
            1: lim = 8'd1;
            2: lim = rand_byte(2, 254);
            3: lim = MAX_LENGTH_RESET;
            default: lim = 8'd20;
         endcase
         wait_drained();
         write_len(lim);
         calm <= (ph == 3);
         if (ph == 0) pressure_req = 1'b1;
         target = sent_bytes + PHASE_BYTES;
         while (sent_bytes < target) begin
            if ($urandom_range(9, 0) == 0) begin
               n = $urandom_range(8, 1);
               repeat (n) send_byte(rand_byte(0, 255), 1'b0, '0);
            end else begin
               send_sentence();
            end
         end
      end
      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d bytes over %0d max_length writes, %0d results checked",
               sent_bytes, settings, results_seen);
      $display("results included %0d checksum mismatches and %0d syntax errors",
               bad_seen, syntax_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> nmea_sentence_checksum_checker.f
rtl/nsc_pkg.sv
rtl/nsc_core.sv
rtl/nmea_sentence_checksum_checker.sv
dv/tb.sv
